### hdl/fdhe_pkg.sv
// ----------------------------------------------------------------------------
// fdhe_pkg
// Shared constants for the fixed-domain histogram entropy unit: register
// indexes, status codes, field and datapath widths and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fdhe_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOMAIN_LOW  = 2'd0,
    CFG_DOMAIN_HIGH = 2'd1,
    CFG_BINS_IN_USE = 2'd2
  } cfg_idx_t;

  // result status codes
  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FEW      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY_DOM = 2'd2;

  // field widths
  localparam int SAMPLE_W  = 32;
  localparam int BINS_W    = 9;
  localparam int ENTROPY_W = 32;
  localparam int CLEAN_W   = 17;

  // datapath widths
  localparam int LOGK_W = 5;              // integer part of log2
  localparam int FRAC_W = 32;             // fraction bits of log2
  localparam int LOG_W  = LOGK_W + FRAC_W;
  localparam int SUM_W  = 64;
  localparam int DVS_W  = 32;             // divisor / remainder width
  localparam int STEP_W = 6;              // iteration counter

  // reset values of the registers
  localparam logic [SAMPLE_W-1:0] DOMAIN_LOW_RST  = 32'sd0;
  localparam logic [SAMPLE_W-1:0] DOMAIN_HIGH_RST = 32'sd65536;
  localparam logic [BINS_W-1:0]   BINS_RST        = 9'd16;

endpackage

`default_nettype wire

### hdl/fixed_domain_histogram_entropy_unit.sv
// ----------------------------------------------------------------------------
// fixed_domain_histogram_entropy_unit
// Bins a set of Q16.16 samples into a histogram memory and, on the last
// sample, sweeps the memory to produce the Shannon entropy in bits (Q8.24).
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+-----------
//  in       | in_valid, in_stall, sample, sample_finite,| into block
//           | last_sample                               |
//  out      | out_valid, out_stall, entropy_bits,       | out of block
//           | clean_samples, status                     |
//  cfg      | cfg_we, cfg_index, cfg_data               | into block
//
//  A counted sample passes through one multiply, a bit-per-cycle bin divider,
//  then a read-modify-write of the bin memory (an empty domain uses bin 0).
//  A set end with an OK status sweeps and clears all MAX_BINS entries, adding
//  a term per non-empty bin via its 32-step log2, then divides by the tally.
//  After reset, in_stall stays high while all MAX_BINS entries are cleared.
//  A waiting result stalls the next set end, not the binning of samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fixed_domain_histogram_entropy_unit #(
  parameter int MAX_BINS    = 256,
  parameter int MAX_SAMPLES = 65536
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // sample channel
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire signed [fdhe_pkg::SAMPLE_W-1:0] sample,
  input  wire                                 sample_finite,
  input  wire                                 last_sample,
  // result channel
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [fdhe_pkg::ENTROPY_W-1:0]      entropy_bits,
  output logic [fdhe_pkg::CLEAN_W-1:0]        clean_samples,
  output logic [fdhe_pkg::STATUS_W-1:0]       status,
  // configuration
  input  wire                                 cfg_we,
  input  wire  [fdhe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [fdhe_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;  // bin address
  localparam int QB  = $clog2(MAX_BINS + 1);                   // bin count value
  localparam int TW  = $clog2(MAX_SAMPLES + 1);                // tally / counts
  localparam int PW  = fdhe_pkg::DVS_W + QB;                   // offset * bins
  localparam int SW  = fdhe_pkg::SUM_W;
  localparam int DW  = fdhe_pkg::DVS_W;
  localparam int LW  = fdhe_pkg::LOG_W;
  localparam int FW  = fdhe_pkg::FRAC_W;
  localparam int KW  = fdhe_pkg::LOGK_W;
  localparam int CW  = fdhe_pkg::STEP_W;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MUL, ST_BDIV, ST_RD, ST_WR, ST_FIN, ST_LNLOG,
    ST_SRD, ST_SCHK, ST_SLOG, ST_SACC, ST_EDIV
  } state_t;

  state_t state;

  // configuration registers
  logic signed [fdhe_pkg::SAMPLE_W-1:0] domain_low;
  logic signed [fdhe_pkg::SAMPLE_W-1:0] domain_high;
  logic [fdhe_pkg::BINS_W-1:0]          bins_in_use;

  // control and datapath registers
  logic [TW-1:0]   tally;
  logic            last_r;
  logic            clr_out;       // clearing pass ends in a result
  logic [fdhe_pkg::STATUS_W-1:0] status_r;
  logic [IW-1:0]   addr;          // sweep address
  logic [IW-1:0]   bin_idx;
  logic [DW-1:0]   offset;        // clamped sample minus domain_low
  logic [CW-1:0]   step;
  logic [DW-1:0]   rem;
  logic [SW-1:0]   dq;
  logic [DW-1:0]   dvs;
  logic [DW-1:0]   lg_m;
  logic [FW-1:0]   lg_frac;
  logic [KW-1:0]   lg_k;
  logic [LW-1:0]   ln;
  logic [LW-1:0]   lc;
  logic [TW-1:0]   cnt_c;
  logic [SW-1:0]   sum;

  // bin memory
  logic [TW-1:0]   mem [MAX_BINS];
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  logic [TW-1:0]   mem_wdata;
  logic [IW-1:0]   mem_raddr;
  logic [TW-1:0]   mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = '0;
    mem_raddr = addr;
    unique case (state)
      ST_CLEAR: mem_we = 1'b1;
      ST_SRD:   mem_we = 1'b1;              // read old count, clear entry
      ST_RD:    mem_raddr = bin_idx;
      ST_WR: begin
        mem_we    = 1'b1;
        mem_waddr = bin_idx;
        mem_wdata = mem_rdata + TW'(1);
      end
      default: ;
    endcase
  end

  // effective bin count, clamped to [1, MAX_BINS]
  logic [QB-1:0] bins_eff;
  always_comb begin
    if (bins_in_use == '0) begin
      bins_eff = QB'(1);
    end else if (32'(bins_in_use) > 32'(MAX_BINS)) begin
      bins_eff = QB'(MAX_BINS);
    end else begin
      bins_eff = QB'(bins_in_use);
    end
  end

  logic dom_ok;
  assign dom_ok = domain_high > domain_low;

  // clamp sample into the domain
  logic signed [fdhe_pkg::SAMPLE_W-1:0] v_clamp;
  logic [DW:0] off_full;
  always_comb begin
    if (sample < domain_low) begin
      v_clamp = domain_low;
    end else if (sample > domain_high) begin
      v_clamp = domain_high;
    end else begin
      v_clamp = sample;
    end
    off_full = (DW+1)'({v_clamp[DW-1], v_clamp} - {domain_low[DW-1], domain_low});
  end

  logic [DW:0] range_full;
  assign range_full = (DW+1)'({domain_high[DW-1], domain_high}
                              - {domain_low[DW-1], domain_low});

  logic [PW-1:0] prod;
  assign prod = PW'(offset) * PW'(bins_eff);

  // restoring divider step, one quotient bit a cycle
  logic [DW+1:0] div_tr;
  logic          div_ok;
  logic [DW-1:0] rem_next;
  logic [SW-1:0] dq_next;
  always_comb begin
    div_tr   = {1'b0, rem, dq[SW-1]} - {2'b00, dvs};
    div_ok   = !div_tr[DW+1];
    rem_next = div_ok ? div_tr[DW-1:0] : {rem[DW-2:0], dq[SW-1]};
    dq_next  = {dq[SW-2:0], div_ok};
  end

  // bin index from the quotient, clamped to the last bin
  logic [QB-1:0] quot;
  logic [IW-1:0] idx_clamped;
  always_comb begin
    quot = dq_next[QB-1:0];
    if (quot > bins_eff - QB'(1)) begin
      idx_clamped = IW'(bins_eff - QB'(1));
    end else begin
      idx_clamped = IW'(quot);
    end
  end

  // log2 start: top set bit and normalized mantissa
  logic [DW-1:0] lg_x;
  logic [KW-1:0] lg_k0;
  logic [DW-1:0] lg_m0;
  always_comb begin
    lg_x  = (state == ST_FIN) ? DW'(tally) : DW'(mem_rdata);
    lg_k0 = '0;
    for (int i = 1; i < DW; i++) begin
      if (lg_x[i]) begin
        lg_k0 = KW'(i);
      end
    end
    lg_m0 = lg_x << (KW'(DW - 1) - lg_k0);
  end

  // log2 fraction step: square, renormalize, emit a bit
  logic [2*DW-1:0] lg_sq;
  logic [DW:0]     lg_s;
  logic [DW-1:0]   lg_m_next;
  logic [FW-1:0]   lg_frac_next;
  always_comb begin
    lg_sq        = (2*DW)'(lg_m) * (2*DW)'(lg_m);
    lg_s         = lg_sq[2*DW-1:DW-1];
    lg_m_next    = lg_s[DW] ? lg_s[DW:1] : lg_s[DW-1:0];
    lg_frac_next = {lg_frac[FW-2:0], lg_s[DW]};
  end

  // weighted term of one bin
  logic [SW-1:0] term;
  assign term = (ln > lc) ? SW'(SW'(cnt_c) * SW'(ln - lc)) : '0;

  // rounding of the final quotient, saturated
  logic [SW:0] q_round;
  logic [fdhe_pkg::ENTROPY_W-1:0] entropy_sat;
  always_comb begin
    q_round = ((SW+1)'(dq_next) + (SW+1)'(128)) >> 8;
    if (q_round > (SW+1)'({fdhe_pkg::ENTROPY_W{1'b1}})) begin
      entropy_sat = '1;
    end else begin
      entropy_sat = q_round[fdhe_pkg::ENTROPY_W-1:0];
    end
  end

  logic last_addr;
  assign last_addr = addr == IW'(MAX_BINS - 1);

  assign in_stall = state != ST_IDLE;

  // control sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      addr        <= '0;
      clr_out     <= 1'b0;
      tally       <= '0;
      out_valid   <= 1'b0;
      domain_low  <= fdhe_pkg::DOMAIN_LOW_RST;
      domain_high <= fdhe_pkg::DOMAIN_HIGH_RST;
      bins_in_use <= fdhe_pkg::BINS_RST;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          fdhe_pkg::CFG_DOMAIN_LOW:  domain_low  <= cfg_data;
          fdhe_pkg::CFG_DOMAIN_HIGH: domain_high <= cfg_data;
          fdhe_pkg::CFG_BINS_IN_USE: bins_in_use <= cfg_data[fdhe_pkg::BINS_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_CLEAR: begin
          if (last_addr) begin
            addr    <= '0;
            clr_out <= 1'b0;
            state   <= ST_IDLE;
            if (clr_out) begin
              out_valid     <= 1'b1;
              entropy_bits  <= '0;
              clean_samples <= fdhe_pkg::CLEAN_W'(tally);
              status        <= status_r;
              tally         <= '0;
            end
          end else begin
            addr <= addr + IW'(1);
          end
        end

        ST_IDLE: begin
          if (in_valid) begin
            last_r <= last_sample;
            if (sample_finite && tally < TW'(MAX_SAMPLES)) begin
              if (dom_ok) begin
                offset <= off_full[DW-1:0];
                state  <= ST_MUL;
              end else begin
                bin_idx <= '0;
                state   <= ST_RD;
              end
            end else if (last_sample) begin
              state <= ST_FIN;
            end
          end
        end

        ST_MUL: begin
          rem   <= DW'(prod >> QB);
          dq    <= SW'(prod[QB-1:0]) << (SW - QB);
          dvs   <= range_full[DW-1:0];
          step  <= CW'(QB - 1);
          state <= ST_BDIV;
        end

        ST_BDIV: begin
          rem  <= rem_next;
          dq   <= dq_next;
          step <= step - CW'(1);
          if (step == '0) begin
            bin_idx <= idx_clamped;
            state   <= ST_RD;
          end
        end

        ST_RD: state <= ST_WR;

        ST_WR: begin
          tally <= tally + TW'(1);
          state <= last_r ? ST_FIN : ST_IDLE;
        end

        ST_FIN: begin
          if (!out_valid) begin
            if (tally < TW'(2)) begin
              status_r <= fdhe_pkg::STATUS_FEW;
              clr_out  <= 1'b1;
              addr     <= '0;
              state    <= ST_CLEAR;
            end else if (!dom_ok) begin
              status_r <= fdhe_pkg::STATUS_EMPTY_DOM;
              clr_out  <= 1'b1;
              addr     <= '0;
              state    <= ST_CLEAR;
            end else begin
              status_r <= fdhe_pkg::STATUS_OK;
              lg_k     <= lg_k0;
              lg_m     <= lg_m0;
              lg_frac  <= '0;
              step     <= CW'(FW - 1);
              state    <= ST_LNLOG;
            end
          end
        end

        ST_LNLOG: begin
          lg_m    <= lg_m_next;
          lg_frac <= lg_frac_next;
          step    <= step - CW'(1);
          if (step == '0) begin
            ln    <= {lg_k, lg_frac_next};
            sum   <= '0;
            addr  <= '0;
            state <= ST_SRD;
          end
        end

        ST_SRD: state <= ST_SCHK;

        ST_SCHK: begin
          cnt_c <= mem_rdata;
          if (mem_rdata != '0) begin
            lg_k    <= lg_k0;
            lg_m    <= lg_m0;
            lg_frac <= '0;
            step    <= CW'(FW - 1);
            state   <= ST_SLOG;
          end else if (last_addr) begin
            rem   <= '0;
            dq    <= sum;
            dvs   <= DW'(tally);
            step  <= CW'(SW - 1);
            state <= ST_EDIV;
          end else begin
            addr  <= addr + IW'(1);
            state <= ST_SRD;
          end
        end

        ST_SLOG: begin
          lg_m    <= lg_m_next;
          lg_frac <= lg_frac_next;
          step    <= step - CW'(1);
          if (step == '0) begin
            lc    <= {lg_k, lg_frac_next};
            state <= ST_SACC;
          end
        end

        ST_SACC: begin
          if (last_addr) begin
            rem   <= '0;
            dq    <= sum + term;
            dvs   <= DW'(tally);
            step  <= CW'(SW - 1);
            state <= ST_EDIV;
          end else begin
            sum   <= sum + term;
            addr  <= addr + IW'(1);
            state <= ST_SRD;
          end
        end

        ST_EDIV: begin
          rem  <= rem_next;
          dq   <= dq_next;
          step <= step - CW'(1);
          if (step == '0) begin
            out_valid     <= 1'b1;
            entropy_bits  <= entropy_sat;
            clean_samples <= fdhe_pkg::CLEAN_W'(tally);
            status        <= status_r;
            tally         <= '0;
            addr          <= '0;
            state         <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### tb/sv/fixed_domain_histogram_entropy_unit_test.sv
// ----------------------------------------------------------------------------
// fixed_domain_histogram_entropy_unit_test
// Self-checking bench for the histogram entropy unit. Sets of samples are
// streamed under random idling on both channels; an in-bench histogram and
// log2 predictor computes each set's entropy, tally and status, and every
// result transfer is compared against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_domain_histogram_entropy_unit_test;

  localparam int NBINS   = 256;
  localparam int NSAMP   = 65536;

  typedef struct {
    logic signed [fdhe_pkg::SAMPLE_W-1:0] value;
    logic                                 finite;
    logic                                 last;
  } sample_t;

  typedef struct {
    logic [fdhe_pkg::ENTROPY_W-1:0] entropy;
    logic [fdhe_pkg::CLEAN_W-1:0]   clean;
    logic [fdhe_pkg::STATUS_W-1:0]  stat;
  } entropy_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [fdhe_pkg::SAMPLE_W-1:0] sample = '0;
  logic sample_finite = 1'b0;
  logic last_sample = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [fdhe_pkg::ENTROPY_W-1:0] entropy_bits;
  logic [fdhe_pkg::CLEAN_W-1:0] clean_samples;
  logic [fdhe_pkg::STATUS_W-1:0] status;
  logic cfg_we = 1'b0;
  logic [fdhe_pkg::CFG_IDX_W-1:0] cfg_index = fdhe_pkg::CFG_DOMAIN_LOW;
  logic [fdhe_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  fixed_domain_histogram_entropy_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .sample_finite(sample_finite), .last_sample(last_sample),
    .out_valid(out_valid), .out_stall(out_stall), .entropy_bits(entropy_bits),
    .clean_samples(clean_samples), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  int unsigned  hist[NBINS];
  int unsigned  tally;
  longint       dom_lo = 0;
  longint       dom_hi = 65536;
  int unsigned  bins_cfg = 16;

  sample_t      pending_samples[$];
  entropy_res_t expected_results[$];
  int           fail_count = 0;
  bit           no_idle = 1'b0;

  // log2 in Q5.32 by repeated squaring of the Q1.31 mantissa
  function automatic longint unsigned log2_q32(input int unsigned x);
    int k;
    longint unsigned m, frac;
    k = 0;
    frac = 0;
    if (x == 0) return 0;
    for (int i = 31; i >= 0; i--) begin
      if (x[i] && k == 0) k = i;
    end
    m = longint'(x) << (31 - k);
    for (int i = 0; i < 32; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(k) << 32) | frac;
  endfunction

  // bin one accepted sample; on the last one predict the set's result
  function automatic void bin_sample(input sample_t s);
    longint v;
    longint unsigned q, b, span, ln, lc, acc, ent;
    entropy_res_t r;
    if (s.finite && tally < NSAMP) begin
      q = 0;
      if (dom_hi > dom_lo) begin
        b = (bins_cfg < 1) ? 1 : (bins_cfg > NBINS) ? NBINS : bins_cfg;
        span = dom_hi - dom_lo;
        v = s.value;
        if (v < dom_lo) v = dom_lo;
        if (v > dom_hi) v = dom_hi;
        q = (longint'(v - dom_lo) * b) / span;
        if (q > b - 1) q = b - 1;
      end
      hist[q]++;
      tally++;
    end
    if (!s.last) return;
    ent = 0;
    if (tally < 2) r.stat = fdhe_pkg::STATUS_FEW;
    else if (dom_hi <= dom_lo) r.stat = fdhe_pkg::STATUS_EMPTY_DOM;
    else begin
      r.stat = fdhe_pkg::STATUS_OK;
      ln = log2_q32(tally);
      acc = 0;
      for (int i = 0; i < NBINS; i++) begin
        if (hist[i] > 0) begin
          lc = log2_q32(hist[i]);
          if (ln > lc) acc += longint'(hist[i]) * (ln - lc);
        end
      end
      ent = ((acc / tally) + 128) >> 8;
      if (ent > 64'hFFFF_FFFF) ent = 64'hFFFF_FFFF;
    end
    r.entropy = ent[31:0];
    r.clean = tally[fdhe_pkg::CLEAN_W-1:0];
    expected_results.push_back(r);
    foreach (hist[i]) hist[i] = 0;
    tally = 0;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sample driver
  int feed_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        bin_sample('{sample, sample_finite, last_sample});
      end
      if (!in_valid || !in_stall) begin
        if (feed_gap > 0) begin
          feed_gap--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          sample_t s;
          s = pending_samples.pop_front();
          sample <= s.value;
          sample_finite <= s.finite;
          last_sample <= s.last;
          in_valid <= 1'b1;
          feed_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and stall generator
  int hold_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer");
          fail_count++;
        end else begin
          entropy_res_t e;
          e = expected_results.pop_front();
          if (entropy_bits !== e.entropy) begin
            $error("entropy_bits expected %h actual %h", e.entropy, entropy_bits);
            fail_count++;
          end
          if (clean_samples !== e.clean) begin
            $error("clean_samples expected %0d actual %0d", e.clean, clean_samples);
            fail_count++;
          end
          if (status !== e.stat) begin
            $error("status expected %0d actual %0d", e.stat, status);
            fail_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        hold_left = pick_gap();
        out_stall <= (hold_left > 0);
      end
    end
  end

  task automatic write_reg(input fdhe_pkg::cfg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      fdhe_pkg::CFG_DOMAIN_LOW:  dom_lo = longint'($signed(val));
      fdhe_pkg::CFG_DOMAIN_HIGH: dom_hi = longint'($signed(val));
      default:                   bins_cfg = val[fdhe_pkg::BINS_W-1:0];
    endcase
  endtask

  task automatic set_domain(input logic [31:0] lo, input logic [31:0] hi,
                            input logic [31:0] nb);
    write_reg(fdhe_pkg::CFG_DOMAIN_LOW, lo);
    write_reg(fdhe_pkg::CFG_DOMAIN_HIGH, hi);
    write_reg(fdhe_pkg::CFG_BINS_IN_USE, nb);
  endtask

  task automatic push(input logic [31:0] v, input logic fin, input logic lst);
    pending_samples.push_back('{v, fin, lst});
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (64) @(negedge clk);
  endtask

  // value mostly inside the current domain, sometimes anywhere
  function automatic logic [31:0] pick_value();
    longint unsigned span, off;
    if (dom_hi <= dom_lo || $urandom_range(0, 9) < 2) return $urandom;
    span = dom_hi - dom_lo + 1;
    off = {$urandom, $urandom} % span;
    return 32'(dom_lo + longint'(off));
  endfunction

  task automatic random_sets(input int n_items);
    int left, len;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 24);
      for (int i = 0; i < len; i++) begin
        push(pick_value(), $urandom_range(0, 9) != 0, i == len - 1);
      end
      left -= len;
    end
  endtask

  initial begin
    foreach (hist[i]) hist[i] = 0;
    tally = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: default domain [0, 1.0], 16 bins
    push(32'h0000_8000, 1'b1, 1'b1);                 // single sample: too few
    push(32'h0000_1000, 1'b0, 1'b0);                 // skipped samples only
    push(32'h7FFF_FFFF, 1'b0, 1'b1);
    push(32'h8000_0000, 1'b1, 1'b0);                 // clamps to low bound
    push(32'h7FFF_FFFF, 1'b1, 1'b0);                 // clamps to top bin
    push(32'h0000_0000, 1'b1, 1'b0);
    push(32'h0001_0000, 1'b1, 1'b0);
    push(32'h0000_FFFF, 1'b0, 1'b1);                 // last flag on a skipped one
    push(32'h0000_4000, 1'b1, 1'b0);                 // two in one bin: zero entropy
    push(32'h0000_4001, 1'b1, 1'b1);
    wait_drained();

    // directed: empty domains, one equal and one inverted
    set_domain(32'h0001_0000, 32'h0001_0000, 0);
    push(32'h1234_5678, 1'b1, 1'b0);
    push(32'h8000_0000, 1'b1, 1'b1);
    wait_drained();
    set_domain(32'h0000_0005, 32'hFFFF_FFFB, 511);
    push(32'h0000_0000, 1'b1, 1'b0);
    push(32'h0000_0001, 1'b1, 1'b0);
    push(32'h0000_0002, 1'b1, 1'b1);
    wait_drained();

    // full signed range, every bin
    set_domain(32'h8000_0000, 32'h7FFF_FFFF, 256);
    for (int i = 0; i < 8; i++) push($urandom, 1'b1, i == 7);
    wait_drained();

    // random phases across a spread of settings
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_domain(32'h8000_0000, 32'h7FFF_FFFF, 256);
        1: set_domain(32'hFFFF_FF9C, 32'h0000_0064, 1);
        2: set_domain(32'h0000_0000, 32'h0000_0003, 255);
        3: set_domain(32'h0000_0007, 32'h0000_0007, 16);
        default: begin
          logic [31:0] a, c;
          a = $urandom;
          c = (ph == 9) ? $urandom : a + $urandom_range(1, 32'h0010_0000);
          set_domain(a, c, $urandom_range(0, 511));
        end
      endcase
      no_idle = (ph == 5);
      random_sets(80);
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("fixed_domain_histogram_entropy_unit_test passed");
    end else begin
      $display("fixed_domain_histogram_entropy_unit_test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #100_000_000;
    $display("fixed_domain_histogram_entropy_unit_test failed");
    $finish;
  end

endmodule

### fixed_domain_histogram_entropy_unit.f
hdl/fdhe_pkg.sv
hdl/fixed_domain_histogram_entropy_unit.sv
tb/sv/fixed_domain_histogram_entropy_unit_test.sv
